/* sv/gttb_pkg.sv */
// ----------------------------------------------------------------------------
// gttb_pkg
// Shared types, constants and the arctangent table for the GPS text to
// bearing unit.
// ----------------------------------------------------------------------------
package gttb_pkg;

  // Defaults for the top-level parameters
  localparam int unsigned ANGLE_FRAC_BITS_DEF = 8;
  localparam int unsigned CORDIC_STEPS_DEF    = 24;

  // Field widths
  localparam int unsigned BEARING_W  = 17;
  localparam int unsigned LAT_POS_W  = 26;
  localparam int unsigned LON_POS_W  = 30;
  localparam int unsigned DLAT_W     = LAT_POS_W + 1;
  localparam int unsigned DLON_W     = LON_POS_W + 1;
  localparam int unsigned CFG_DATA_W = LON_POS_W;

  // CORDIC datapath: differences scaled by 2^20, room for the gain
  localparam int unsigned PRESCALE   = 20;
  localparam int unsigned CW         = 56;
  localparam int unsigned STEP_W     = 5;
  localparam int unsigned ANG_W      = 32;

  // Queue between front and back
  localparam int unsigned QDEPTH     = 2;
  localparam int unsigned QPTR_W     = $clog2(QDEPTH);
  localparam int unsigned QCNT_W     = $clog2(QDEPTH + 1);

  // Configuration register indexes
  localparam logic CFG_TARGET_LAT = 1'b0;
  localparam logic CFG_TARGET_LON = 1'b1;

  // ASCII digit bounds
  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_NINE = 8'h39;

  // Classification of one word
  typedef enum logic [1:0] {
    KIND_OK     = 2'd0,
    KIND_NOFIX  = 2'd1,
    KIND_BADDIG = 2'd2
  } kind_t;

  // One queue entry
  typedef struct packed {
    kind_t                     kind;
    logic signed [DLAT_W-1:0]  dlat;
    logic signed [DLON_W-1:0]  dlon;
  } qentry_t;

  // atan(2^-i) as a fraction of a full turn, 2^32 = 360 degrees
  function automatic logic [ANG_W-1:0] atan_turn(input logic [STEP_W-1:0] idx);
    logic [ANG_W-1:0] v;
    unique case (idx)
      5'd0:  v = 32'd536870912;
      5'd1:  v = 32'd316933406;
      5'd2:  v = 32'd167458907;
      5'd3:  v = 32'd85004756;
      5'd4:  v = 32'd42667331;
      5'd5:  v = 32'd21354465;
      5'd6:  v = 32'd10679838;
      5'd7:  v = 32'd5340245;
      5'd8:  v = 32'd2670163;
      5'd9:  v = 32'd1335087;
      5'd10: v = 32'd667544;
      5'd11: v = 32'd333772;
      5'd12: v = 32'd166886;
      5'd13: v = 32'd83443;
      5'd14: v = 32'd41722;
      5'd15: v = 32'd20861;
      5'd16: v = 32'd10430;
      5'd17: v = 32'd5215;
      5'd18: v = 32'd2608;
      5'd19: v = 32'd1304;
      5'd20: v = 32'd652;
      5'd21: v = 32'd326;
      5'd22: v = 32'd163;
      5'd23: v = 32'd81;
      5'd24: v = 32'd41;
      5'd25: v = 32'd20;
      5'd26: v = 32'd10;
      5'd27: v = 32'd5;
      5'd28: v = 32'd3;
      5'd29: v = 32'd1;
      5'd30: v = 32'd1;
      5'd31: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

/* sv/gps_text_to_bearing_unit.sv */
// ----------------------------------------------------------------------------
// gps_text_to_bearing_unit
// Bearing from one NMEA-style GPS fix to a configured target position.
// ----------------------------------------------------------------------------
// Each input word carries a fix flag and latitude/longitude as ASCII text
// (ddmm.mmmm and dddmm.mmmm). The front checks and converts the text to
// 1e-4 arc-minute and takes the difference to the target registers in its
// digit, position and push states; the back turns it into a bearing in
// 1/2^ANGLE_FRAC_BITS degree, clockwise from north, using an iterative
// CORDIC that does one rotation per cycle. A valid fix passes through that
// single shift-add rotation unit, then a multiply and a final rounding
// state; a word with no fix or a bad digit returns the last bearing with
// fix_lost or format_error raised. A two-word queue lets the front take the
// next word while the back is busy. Write the target registers only while
// the unit is idle.
module gps_text_to_bearing_unit #(
  parameter int unsigned ANGLE_FRAC_BITS = gttb_pkg::ANGLE_FRAC_BITS_DEF,
  parameter int unsigned CORDIC_STEPS    = gttb_pkg::CORDIC_STEPS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // configuration write
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic                             cfg_index,
  input  logic [gttb_pkg::CFG_DATA_W-1:0]  cfg_data,
  // input words
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             in_fix_valid,
  input  logic [63:0]                      in_lat_text_high,
  input  logic [7:0]                       in_lat_text_low,
  input  logic [63:0]                      in_lon_text_high,
  input  logic [15:0]                      in_lon_text_low,
  // result words
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [gttb_pkg::BEARING_W-1:0]   out_bearing,
  output logic                             out_fix_lost,
  output logic                             out_format_error
);

  logic [gttb_pkg::LAT_POS_W-1:0] tgt_lat_r;
  logic [gttb_pkg::LON_POS_W-1:0] tgt_lon_r;

  logic              q_push, q_full, q_pop, q_not_empty;
  gttb_pkg::qentry_t q_wdata, q_rdata;

  assign cfg_ready = 1'b1;

  // Target registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tgt_lat_r <= '0;
      tgt_lon_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        gttb_pkg::CFG_TARGET_LAT: tgt_lat_r <= cfg_data[gttb_pkg::LAT_POS_W-1:0];
        gttb_pkg::CFG_TARGET_LON: tgt_lon_r <= cfg_data[gttb_pkg::LON_POS_W-1:0];
        default: ;
      endcase
    end
  end

  gttb_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .fix_valid     (in_fix_valid),
    .lat_text_high (in_lat_text_high),
    .lat_text_low  (in_lat_text_low),
    .lon_text_high (in_lon_text_high),
    .lon_text_low  (in_lon_text_low),
    .tgt_lat       (tgt_lat_r),
    .tgt_lon       (tgt_lon_r),
    .q_push        (q_push),
    .q_data        (q_wdata),
    .q_full        (q_full)
  );

  gttb_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .pop_data  (q_rdata)
  );

  gttb_back #(
    .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS),
    .CORDIC_STEPS    (CORDIC_STEPS)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_not_empty      (q_not_empty),
    .q_data           (q_rdata),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_bearing      (out_bearing),
    .out_fix_lost     (out_fix_lost),
    .out_format_error (out_format_error)
  );

  // A result never carries both flags
  a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_fix_lost && out_format_error))
    else $error("fix_lost and format_error both set");

  // The front works on one word at a time
  a_front_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("front accepted a word without going busy");

  // Never push into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_full |-> !q_push)
    else $error("push into full queue");

  // Never pop an empty queue
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_not_empty)
    else $error("pop from empty queue");

endmodule

/* sv/gttb_front.sv */
// ----------------------------------------------------------------------------
// gttb_front
// Accepts a fix word, checks the digit characters, converts latitude and
// longitude text to 1e-4 arc-minute and pushes the target differences.
// ----------------------------------------------------------------------------
module gttb_front (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                fix_valid,
  input  logic [63:0]                         lat_text_high,
  input  logic [7:0]                          lat_text_low,
  input  logic [63:0]                         lon_text_high,
  input  logic [15:0]                         lon_text_low,
  input  logic [gttb_pkg::LAT_POS_W-1:0]      tgt_lat,
  input  logic [gttb_pkg::LON_POS_W-1:0]      tgt_lon,
  output logic                                q_push,
  output gttb_pkg::qentry_t                   q_data,
  input  logic                                q_full
);

  typedef enum logic [3:0] {
    F_IDLE  = 4'b0001,
    F_DIGIT = 4'b0010,
    F_POS   = 4'b0100,
    F_PUSH  = 4'b1000
  } fstate_t;

  fstate_t fst_r, fst_nxt;

  // Raw text, char 0 in the top byte
  logic        fix_r;
  logic [71:0] lat_r;
  logic [79:0] lon_r;

  // Decoded fields
  gttb_pkg::kind_t kind_r, kind_nxt;
  logic [6:0]  lat_deg_r, lat_deg_nxt;
  logic [6:0]  lat_min_r, lat_min_nxt;
  logic [13:0] lat_frac_r, lat_frac_nxt;
  logic [9:0]  lon_deg_r, lon_deg_nxt;
  logic [6:0]  lon_min_r, lon_min_nxt;
  logic [13:0] lon_frac_r, lon_frac_nxt;

  // Positions
  logic [gttb_pkg::LAT_POS_W-1:0] lat_pos_r, lat_pos_nxt;
  logic [gttb_pkg::LON_POS_W-1:0] lon_pos_r, lon_pos_nxt;

  logic [3:0] la [9];
  logic [3:0] lo [10];
  logic       bad;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= gttb_pkg::CHAR_ZERO) && (c <= gttb_pkg::CHAR_NINE);
  endfunction

  assign in_stall = (fst_r != F_IDLE);

  // Digit values from the low nibble and format check; point positions are skipped
  always_comb begin
    bad = 1'b0;
    for (int k = 0; k < 9; k++) begin
      la[k] = lat_r[67 - 8*k -: 4];
      if (k != 4 && !is_digit(lat_r[71 - 8*k -: 8])) bad = 1'b1;
    end
    for (int k = 0; k < 10; k++) begin
      lo[k] = lon_r[75 - 8*k -: 4];
      if (k != 5 && !is_digit(lon_r[79 - 8*k -: 8])) bad = 1'b1;
    end
  end

  // Degrees, minutes and fractional minutes per coordinate
  always_comb begin
    lat_deg_nxt  = 7'(la[0]) * 7'd10 + 7'(la[1]);
    lat_min_nxt  = 7'(la[2]) * 7'd10 + 7'(la[3]);
    lat_frac_nxt = 14'(la[5]) * 14'd1000 + 14'(la[6]) * 14'd100
                 + 14'(la[7]) * 14'd10 + 14'(la[8]);
    lon_deg_nxt  = 10'(lo[0]) * 10'd100 + 10'(lo[1]) * 10'd10 + 10'(lo[2]);
    lon_min_nxt  = 7'(lo[3]) * 7'd10 + 7'(lo[4]);
    lon_frac_nxt = 14'(lo[6]) * 14'd1000 + 14'(lo[7]) * 14'd100
                 + 14'(lo[8]) * 14'd10 + 14'(lo[9]);
    if (!fix_r)   kind_nxt = gttb_pkg::KIND_NOFIX;
    else if (bad) kind_nxt = gttb_pkg::KIND_BADDIG;
    else          kind_nxt = gttb_pkg::KIND_OK;
  end

  // Positions in 1e-4 arc-minute
  always_comb begin
    lat_pos_nxt = gttb_pkg::LAT_POS_W'(lat_deg_r) * gttb_pkg::LAT_POS_W'(600000)
                + gttb_pkg::LAT_POS_W'(lat_min_r) * gttb_pkg::LAT_POS_W'(10000)
                + gttb_pkg::LAT_POS_W'(lat_frac_r);
    lon_pos_nxt = gttb_pkg::LON_POS_W'(lon_deg_r) * gttb_pkg::LON_POS_W'(600000)
                + gttb_pkg::LON_POS_W'(lon_min_r) * gttb_pkg::LON_POS_W'(10000)
                + gttb_pkg::LON_POS_W'(lon_frac_r);
  end

  // Differences to target and push
  always_comb begin
    q_data.kind = kind_r;
    q_data.dlat = $signed({1'b0, tgt_lat}) - $signed({1'b0, lat_pos_r});
    q_data.dlon = $signed({1'b0, tgt_lon}) - $signed({1'b0, lon_pos_r});
    q_push      = (fst_r == F_PUSH) && !q_full;
  end

  // Sequence one word through the front
  always_comb begin
    fst_nxt = fst_r;
    unique case (fst_r)
      F_IDLE:  if (in_valid) fst_nxt = F_DIGIT;
      F_DIGIT: fst_nxt = F_POS;
      F_POS:   fst_nxt = F_PUSH;
      F_PUSH:  if (!q_full) fst_nxt = F_IDLE;
      default: fst_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fst_r <= F_IDLE;
    end else begin
      fst_r <= fst_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (fst_r == F_IDLE && in_valid) begin
      fix_r <= fix_valid;
      lat_r <= {lat_text_high, lat_text_low};
      lon_r <= {lon_text_high, lon_text_low};
    end
    if (fst_r == F_DIGIT) begin
      kind_r     <= kind_nxt;
      lat_deg_r  <= lat_deg_nxt;
      lat_min_r  <= lat_min_nxt;
      lat_frac_r <= lat_frac_nxt;
      lon_deg_r  <= lon_deg_nxt;
      lon_min_r  <= lon_min_nxt;
      lon_frac_r <= lon_frac_nxt;
    end
    if (fst_r == F_POS) begin
      lat_pos_r <= lat_pos_nxt;
      lon_pos_r <= lon_pos_nxt;
    end
  end

endmodule

/* sv/gttb_queue.sv */
// ----------------------------------------------------------------------------
// gttb_queue
// Short FIFO of classified words between the front and the back.
// ----------------------------------------------------------------------------
module gttb_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  gttb_pkg::qentry_t push_data,
  output logic              full,
  input  logic              pop,
  output logic              not_empty,
  output gttb_pkg::qentry_t pop_data
);

  gttb_pkg::qentry_t                entry_r [gttb_pkg::QDEPTH];
  logic [gttb_pkg::QPTR_W-1:0]      wr_ptr_r, wr_ptr_nxt;
  logic [gttb_pkg::QPTR_W-1:0]      rd_ptr_r, rd_ptr_nxt;
  logic [gttb_pkg::QCNT_W-1:0]      cnt_r, cnt_nxt;

  localparam logic [gttb_pkg::QPTR_W-1:0] LAST_PTR = gttb_pkg::QPTR_W'(gttb_pkg::QDEPTH - 1);

  assign full      = (cnt_r == gttb_pkg::QCNT_W'(gttb_pkg::QDEPTH));
  assign not_empty = (cnt_r != '0);
  assign pop_data  = entry_r[rd_ptr_r];

  // Advance pointers and count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    if (pop)  rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    if (push && !pop)      cnt_nxt = cnt_r + 1'b1;
    else if (!push && pop) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Store the pushed word
  always_ff @(posedge clk) begin
    if (push) entry_r[wr_ptr_r] <= push_data;
  end

endmodule

/* sv/gttb_back.sv */
// ----------------------------------------------------------------------------
// gttb_back
// Iterative vectoring CORDIC on the target differences, scaling of the
// angle to degree steps, held bearing and the output register.
// ----------------------------------------------------------------------------
module gttb_back #(
  parameter int unsigned ANGLE_FRAC_BITS = gttb_pkg::ANGLE_FRAC_BITS_DEF,
  parameter int unsigned CORDIC_STEPS    = gttb_pkg::CORDIC_STEPS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            q_not_empty,
  input  gttb_pkg::qentry_t               q_data,
  output logic                            q_pop,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [gttb_pkg::BEARING_W-1:0]  out_bearing,
  output logic                            out_fix_lost,
  output logic                            out_format_error
);

  localparam int unsigned CW     = gttb_pkg::CW;
  localparam int unsigned BW     = gttb_pkg::BEARING_W;
  localparam int unsigned FULL   = 360 << ANGLE_FRAC_BITS;
  localparam int unsigned FULL_W = $clog2(FULL + 1);
  localparam int unsigned PW     = gttb_pkg::ANG_W + FULL_W;
  localparam logic [FULL_W-1:0]           FULL_V    = FULL_W'(FULL);
  localparam logic [PW-1:0]               HALF      = PW'(64'h8000_0000);
  localparam logic [gttb_pkg::STEP_W-1:0] LAST_STEP = gttb_pkg::STEP_W'(CORDIC_STEPS - 1);

  typedef enum logic [3:0] {
    B_IDLE = 4'b0001,
    B_ROT  = 4'b0010,
    B_MUL  = 4'b0100,
    B_FIN  = 4'b1000
  } bstate_t;

  bstate_t bst_r, bst_nxt;

  logic signed [CW-1:0]          x_r, x_nxt, y_r, y_nxt;
  logic [gttb_pkg::ANG_W-1:0]    ang_r, ang_nxt;
  logic [gttb_pkg::STEP_W-1:0]   step_r, step_nxt;
  logic                          zero_r, zero_nxt;
  logic [PW-1:0]                 prod_r;
  logic [BW-1:0]                 last_r, last_nxt;

  logic                          out_valid_r, out_valid_nxt;
  logic [BW-1:0]                 out_bearing_r, out_bearing_nxt;
  logic                          out_fix_lost_r, out_fix_lost_nxt;
  logic                          out_format_error_r, out_format_error_nxt;

  logic                          out_free;
  logic signed [CW-1:0]          x0, y0, xs, ys;
  logic                          y_pos;
  logic [PW-1:0]                 rounded;
  logic [FULL_W-1:0]             scaled;
  logic [BW+FULL_W-1:0]          scaled_ext;
  logic [BW-1:0]                 result;

  assign out_free         = !out_valid_r || !out_stall;
  assign out_valid        = out_valid_r;
  assign out_bearing      = out_bearing_r;
  assign out_fix_lost     = out_fix_lost_r;
  assign out_format_error = out_format_error_r;

  // Prescaled start vector
  always_comb begin
    x0 = CW'(q_data.dlat) <<< gttb_pkg::PRESCALE;
    y0 = CW'(q_data.dlon) <<< gttb_pkg::PRESCALE;
  end

  // One shared shift-add rotation
  always_comb begin
    xs    = x_r >>> step_r;
    ys    = y_r >>> step_r;
    y_pos = !y_r[CW-1] && (y_r != '0);
  end

  // Round angle to degree steps, wrap full circle and a zero vector to zero
  always_comb begin
    rounded    = prod_r + HALF;
    scaled     = rounded[PW-1:gttb_pkg::ANG_W];
    scaled_ext = {{BW{1'b0}}, scaled};
    if (zero_r || scaled >= FULL_V) result = '0;
    else                            result = scaled_ext[BW-1:0];
  end

  always_comb begin
    bst_nxt              = bst_r;
    x_nxt                = x_r;
    y_nxt                = y_r;
    ang_nxt              = ang_r;
    step_nxt             = step_r;
    zero_nxt             = zero_r;
    last_nxt             = last_r;
    q_pop                = 1'b0;
    out_valid_nxt        = out_valid_r && out_stall;
    out_bearing_nxt      = out_bearing_r;
    out_fix_lost_nxt     = out_fix_lost_r;
    out_format_error_nxt = out_format_error_r;
    unique case (bst_r)
      B_IDLE: begin
        if (q_not_empty) begin
          if (q_data.kind == gttb_pkg::KIND_OK) begin
            // Load the vector, fold the left half plane over
            q_pop    = 1'b1;
            zero_nxt = (q_data.dlat == '0) && (q_data.dlon == '0);
            step_nxt = '0;
            if (q_data.dlat[gttb_pkg::DLAT_W-1]) begin
              x_nxt   = -x0;
              y_nxt   = -y0;
              ang_nxt = 32'h8000_0000;
            end else begin
              x_nxt   = x0;
              y_nxt   = y0;
              ang_nxt = '0;
            end
            bst_nxt = B_ROT;
          end else if (out_free) begin
            // Hold the last bearing and flag the word
            q_pop                = 1'b1;
            out_valid_nxt        = 1'b1;
            out_bearing_nxt      = last_r;
            out_fix_lost_nxt     = (q_data.kind == gttb_pkg::KIND_NOFIX);
            out_format_error_nxt = (q_data.kind == gttb_pkg::KIND_BADDIG);
          end
        end
      end
      B_ROT: begin
        if (y_pos) begin
          x_nxt   = x_r + ys;
          y_nxt   = y_r - xs;
          ang_nxt = ang_r + gttb_pkg::atan_turn(step_r);
        end else begin
          x_nxt   = x_r - ys;
          y_nxt   = y_r + xs;
          ang_nxt = ang_r - gttb_pkg::atan_turn(step_r);
        end
        step_nxt = step_r + 1'b1;
        if (step_r == LAST_STEP) bst_nxt = B_MUL;
      end
      B_MUL: begin
        bst_nxt = B_FIN;
      end
      B_FIN: begin
        if (out_free) begin
          last_nxt             = result;
          out_valid_nxt        = 1'b1;
          out_bearing_nxt      = result;
          out_fix_lost_nxt     = 1'b0;
          out_format_error_nxt = 1'b0;
          bst_nxt              = B_IDLE;
        end
      end
      default: bst_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bst_r       <= B_IDLE;
      out_valid_r <= 1'b0;
      last_r      <= '0;
    end else begin
      bst_r       <= bst_nxt;
      out_valid_r <= out_valid_nxt;
      last_r      <= last_nxt;
    end
  end

  // Datapath and output payload
  always_ff @(posedge clk) begin
    x_r                <= x_nxt;
    y_r                <= y_nxt;
    ang_r              <= ang_nxt;
    step_r             <= step_nxt;
    zero_r             <= zero_nxt;
    out_bearing_r      <= out_bearing_nxt;
    out_fix_lost_r     <= out_fix_lost_nxt;
    out_format_error_r <= out_format_error_nxt;
    if (bst_r == B_MUL) prod_r <= PW'(ang_r) * PW'(FULL_V);
  end

endmodule
